// ----- sv/jdist_pkg.sv -----
// Package for the 2x2 Jacobian distortion core: request and response
// transaction types. No dependencies.
package jdist_pkg;

   localparam int unsigned QBITS = 32;  // quotient bits produced by the divider

   typedef struct packed {
      logic signed [31:0] ref_m11;
      logic signed [31:0] ref_m12;
      logic signed [31:0] ref_m21;
      logic signed [31:0] ref_m22;
      logic signed [31:0] tgt_m11;
      logic signed [31:0] tgt_m12;
      logic signed [31:0] tgt_m21;
      logic signed [31:0] tgt_m22;
      logic               on_boundary;
   } req_type;

   typedef struct packed {
      logic signed [31:0] area_ratio;
      logic signed [31:0] trace_sum;
      logic signed [31:0] rotation_term;
      logic               singular;
   } rsp_type;

endpackage

// ----- sv/jacobian_distortion_2x2_core.sv -----
// Top level of the 2x2 Jacobian distortion core: products, sums, singular
// test and a 32-stage restoring divider for three quotients. Uses jdist_pkg.
//
// Usage
//   Request channel: drive req_data and raise start; a transaction is taken
//   on every clock edge where start is high and busy is low. busy is always
//   low, so one mesh point can enter per cycle.
//   Response channel: rsp_valid is high for one cycle with rsp_data; the
//   receiver cannot stall and must take it in that cycle.
//   Config: csr_we writes csr_wdata into the singular threshold (reset 1).
//   Write it only while no transaction is in flight.
// Pipeline and throughput
//   One multiply stage, two sum/abs stages, one threshold/overflow stage,
//   32 divider stages (one quotient bit each, all three quotients side by
//   side) and an output stage for saturation and sign, all registered
//   between accept and rsp_valid. Throughput is one point per cycle.
// Reset
//   Synchronous active-high reset clears all stage valid bits and sets the
//   threshold to 1; in-flight transactions are dropped.
module jacobian_distortion_2x2_core
   import jdist_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned RW  = (66 + FRAC_BITS > 97) ? 66 + FRAC_BITS : 97;
   localparam int unsigned LAT = 5 + QBITS;

   typedef struct packed {
      logic            valid;
      logic            boundary;
      logic            sing;
      logic [63:0]     dmag;
      logic [2:0]      neg;
      logic [2:0]      ovf;
      logic [2:0][RW-1:0]    rem;
      logic [2:0][QBITS-1:0] quo;
   } div_type;

   logic [31:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= 32'd1;
      end else if (csr_we) begin
         thresh_ff <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   // stage 1: products
   logic               s1_valid_ff;
   logic               s1_bnd_ff;
   logic signed [63:0] prod_ff [12];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_bnd_ff   <= req_data.on_boundary;
      prod_ff[0]  <= req_data.ref_m11 * req_data.ref_m22;
      prod_ff[1]  <= req_data.ref_m12 * req_data.ref_m21;
      prod_ff[2]  <= req_data.tgt_m11 * req_data.tgt_m22;
      prod_ff[3]  <= req_data.tgt_m12 * req_data.tgt_m21;
      prod_ff[4]  <= req_data.ref_m22 * req_data.tgt_m11;
      prod_ff[5]  <= req_data.ref_m11 * req_data.tgt_m22;
      prod_ff[6]  <= req_data.ref_m12 * req_data.tgt_m21;
      prod_ff[7]  <= req_data.ref_m21 * req_data.tgt_m12;
      prod_ff[8]  <= req_data.ref_m22 * req_data.tgt_m12;
      prod_ff[9]  <= req_data.ref_m21 * req_data.tgt_m11;
      prod_ff[10] <= req_data.ref_m12 * req_data.tgt_m22;
      prod_ff[11] <= req_data.ref_m11 * req_data.tgt_m21;
   end

   // stage 2: determinants and adjugate sums, 66-bit signed
   logic               s2_valid_ff;
   logic               s2_bnd_ff;
   logic signed [65:0] deta_ff;
   logic signed [65:0] num_ff [3];
   logic signed [65:0] px [12];

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         px[i] = {{2{prod_ff[i][63]}}, prod_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_bnd_ff <= s1_bnd_ff;
      deta_ff   <= px[0] - px[1];
      num_ff[0] <= px[2] - px[3];
      num_ff[1] <= (px[4] + px[5]) - (px[6] + px[7]);
      num_ff[2] <= (px[8] + px[9]) - (px[10] + px[11]);
   end

   // stage 3: magnitudes and quotient signs
   logic        s3_valid_ff;
   logic        s3_bnd_ff;
   logic [63:0] dmag_ff;
   logic [2:0]  neg_ff;
   logic [64:0] nmag_ff [3];
   logic [65:0] deta_abs;
   logic [65:0] num_abs [3];

   always_comb begin
      deta_abs = deta_ff[65] ? 66'(-deta_ff) : 66'(deta_ff);
      for (int i = 0; i < 3; i++) begin
         num_abs[i] = num_ff[i][65] ? 66'(-num_ff[i]) : 66'(num_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_bnd_ff <= s2_bnd_ff;
      dmag_ff   <= deta_abs[63:0];
      for (int i = 0; i < 3; i++) begin
         nmag_ff[i] <= num_abs[i][64:0];
         neg_ff[i]  <= num_ff[i][65] ^ deta_ff[65];
      end
   end

   // stage 4: singular test, scaled numerators, overflow check
   div_type pipe_ff [QBITS+1];
   div_type pipe0_in;
   logic [RW-1:0] dtop;

   always_comb begin
      pipe0_in          = '0;
      pipe0_in.valid    = s3_valid_ff;
      pipe0_in.boundary = s3_bnd_ff;
      pipe0_in.sing     = (dmag_ff == 64'd0) || (dmag_ff < {32'd0, thresh_ff});
      pipe0_in.dmag     = dmag_ff;
      pipe0_in.neg      = neg_ff;
      dtop              = RW'(dmag_ff) << QBITS;
      for (int i = 0; i < 3; i++) begin
         pipe0_in.rem[i] = RW'(nmag_ff[i]) << FRAC_BITS;
         pipe0_in.ovf[i] = pipe0_in.rem[i] >= dtop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_ff[0].valid <= 1'b0;
      end else begin
         pipe_ff[0].valid <= pipe0_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      pipe_ff[0].boundary <= pipe0_in.boundary;
      pipe_ff[0].sing     <= pipe0_in.sing;
      pipe_ff[0].dmag     <= pipe0_in.dmag;
      pipe_ff[0].neg      <= pipe0_in.neg;
      pipe_ff[0].ovf      <= pipe0_in.ovf;
      pipe_ff[0].rem      <= pipe0_in.rem;
      pipe_ff[0].quo      <= pipe0_in.quo;
   end

   // divider: stage g decides quotient bit QBITS-1-g for all three lanes
   for (genvar g = 0; g < QBITS; g++) begin : g_div
      localparam int unsigned K = QBITS - 1 - g;
      div_type       stage_in;
      logic [RW-1:0] dk;

      always_comb begin
         stage_in = pipe_ff[g];
         dk       = RW'(pipe_ff[g].dmag) << K;
         for (int i = 0; i < 3; i++) begin
            if (pipe_ff[g].rem[i] >= dk) begin
               stage_in.rem[i]    = pipe_ff[g].rem[i] - dk;
               stage_in.quo[i][K] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_ff[g+1].valid <= 1'b0;
         end else begin
            pipe_ff[g+1].valid <= stage_in.valid;
         end
      end

      always_ff @(posedge clock) begin
         pipe_ff[g+1].boundary <= stage_in.boundary;
         pipe_ff[g+1].sing     <= stage_in.sing;
         pipe_ff[g+1].dmag     <= stage_in.dmag;
         pipe_ff[g+1].neg      <= stage_in.neg;
         pipe_ff[g+1].ovf      <= stage_in.ovf;
         pipe_ff[g+1].rem      <= stage_in.rem;
         pipe_ff[g+1].quo      <= stage_in.quo;
      end
   end

   // output stage: saturate, apply sign, zero singular/boundary points
   div_type     last;
   logic [31:0] res [3];
   logic [31:0] lim;
   logic [31:0] qsat;
   logic        zero_out;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   always_comb begin
      last     = pipe_ff[QBITS];
      zero_out = last.sing || last.boundary;
      lim      = '0;
      qsat     = '0;
      for (int i = 0; i < 3; i++) begin
         lim  = last.neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         qsat = (last.ovf[i] || (last.quo[i] > lim)) ? lim : last.quo[i];
         res[i] = zero_out ? 32'd0 : (last.neg[i] ? 32'(-qsat) : qsat);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff.area_ratio    <= res[0];
      rsp_data_ff.trace_sum     <= res[1];
      rsp_data_ff.rotation_term <= res[2];
      rsp_data_ff.singular      <= last.sing;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // fixed latency: every response traces back to an accepted request
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("response without matching request");

   // a singular point never carries nonzero measures
   a_sing_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.singular) |->
         (rsp_data.area_ratio == 0 && rsp_data.trace_sum == 0 &&
          rsp_data.rotation_term == 0))
      else $error("singular point with nonzero result");

   // a point that reaches the divider unmasked has a nonzero divisor
   a_div_nonzero : assert property (@(posedge clock) disable iff (reset)
      (pipe_ff[0].valid && !pipe_ff[0].sing) |-> (pipe_ff[0].dmag != 64'd0))
      else $error("zero divisor entered divider");

endmodule

// ----- dv/tb_jacobian_distortion_2x2_core.sv -----
// Testbench for jacobian_distortion_2x2_core: directed and random mesh points checked
// against a predictor of det(J), trace(J) and J12-J21. Depends on jdist_pkg and the core.
module tb_jacobian_distortion_2x2_core
   import jdist_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam int LATENCY = 37;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   logic [31:0] threshold_model;
   rsp_type     expected_q[$];
   int          n_err = 0;
   int          n_sent = 0;
   int          n_singular = 0;
   int          n_checked = 0;

   jacobian_distortion_2x2_core #(.FRAC_BITS(FRAC)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // truncating signed division of num<<FRAC by det, saturated to 32 bits
   function automatic logic [31:0] fixed_quotient(logic signed [127:0] num,
                                                  logic signed [127:0] det);
      logic [127:0] nmag, dmag, q;
      logic         neg;
      nmag = num[127] ? -num : num;
      dmag = det[127] ? -det : det;
      neg  = num[127] ^ det[127];
      q = (nmag << FRAC) / dmag;
      if (neg) begin
         if (q > 128'h8000_0000) q = 128'h8000_0000;
         return -q[31:0];
      end
      if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
      return q[31:0];
   endfunction

   function automatic rsp_type predict_distortion(req_type p);
      logic signed [127:0] a11, a12, a21, a22, b11, b12, b21, b22, det_a, det_b, tr, rot;
      logic [127:0]        amag;
      rsp_type             r;
      a11 = p.ref_m11; a12 = p.ref_m12; a21 = p.ref_m21; a22 = p.ref_m22;
      b11 = p.tgt_m11; b12 = p.tgt_m12; b21 = p.tgt_m21; b22 = p.tgt_m22;
      det_a = a11 * a22 - a12 * a21;
      amag = det_a[127] ? -det_a : det_a;
      r = '0;
      r.singular = (amag < {96'd0, threshold_model}) || (amag == 0);
      if (r.singular || p.on_boundary) return r;
      det_b = b11 * b22 - b12 * b21;
      tr  = a22 * b11 + a11 * b22 - a12 * b21 - a21 * b12;
      rot = a22 * b12 + a21 * b11 - a12 * b22 - a11 * b21;
      r.area_ratio    = fixed_quotient(det_b, det_a);
      r.trace_sum     = fixed_quotient(tr, det_a);
      r.rotation_term = fixed_quotient(rot, det_a);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result transaction");
            n_err++;
         end else begin
            e = expected_q.pop_front();
            n_checked++;
            if (rsp_data.area_ratio !== e.area_ratio) begin
               $error("area_ratio exp %h act %h", e.area_ratio, rsp_data.area_ratio);
               n_err++;
            end
            if (rsp_data.trace_sum !== e.trace_sum) begin
               $error("trace_sum exp %h act %h", e.trace_sum, rsp_data.trace_sum);
               n_err++;
            end
            if (rsp_data.rotation_term !== e.rotation_term) begin
               $error("rotation_term exp %h act %h", e.rotation_term,
                      rsp_data.rotation_term);
               n_err++;
            end
            if (rsp_data.singular !== e.singular) begin
               $error("singular exp %b act %b", e.singular, rsp_data.singular);
               n_err++;
            end
         end
      end
   end

   // drops start only when it actually waits
   task automatic idle_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 60) return;
      start <= 1'b0;
      repeat (k < 95 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(negedge clock);
   endtask

   // drives one point and holds it until accepted; start stays high into the next one
   task automatic send_point(req_type p, bit gaps = 1'b1);
      req_data <= p;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      expected_q.push_back(predict_distortion(p));
      n_sent++;
      if (p.on_boundary == 1'b0 && expected_q[$].singular) n_singular++;
      @(negedge clock);
      if (gaps && $urandom_range(0, 3) == 0) begin
         idle_gap();
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   task automatic write_threshold(logic [31:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      threshold_model = v;
   endtask

   function automatic logic [31:0] rand_value(int mode);
      case (mode)
         0: return $urandom();
         1: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
         2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0001_0000;
               3: return 32'hFFFF_0000;
               default: return 32'h0;
            endcase
         end
      endcase
   endfunction

   function automatic req_type rand_point();
      req_type p;
      int      mode;
      mode = $urandom_range(0, 9);
      mode = mode < 2 ? 0 : mode < 5 ? 1 : mode < 8 ? 2 : 3;
      p.ref_m11 = rand_value(mode); p.ref_m12 = rand_value(mode);
      p.ref_m21 = rand_value(mode); p.ref_m22 = rand_value(mode);
      p.tgt_m11 = rand_value($urandom_range(0, 3));
      p.tgt_m12 = rand_value($urandom_range(0, 3));
      p.tgt_m21 = rand_value($urandom_range(0, 3));
      p.tgt_m22 = rand_value($urandom_range(0, 3));
      // near-singular reference: second row copies the first, with a small offset on m22
      if ($urandom_range(0, 9) == 0) begin
         p.ref_m21 = p.ref_m11;
         p.ref_m22 = p.ref_m12 + $signed($urandom_range(0, 4)) - 2;
      end
      p.on_boundary = ($urandom_range(0, 9) == 0);
      return p;
   endfunction

   function automatic req_type make_point(logic [31:0] a11, a12, a21, a22,
                                          logic [31:0] b11, b12, b21, b22, bit bnd);
      req_type p;
      p = '{a11, a12, a21, a22, b11, b12, b21, b22, bnd};
      return p;
   endfunction

   task automatic test_directed();
      send_point(make_point(32'h10000, 0, 0, 32'h10000, 32'h10000, 0, 0, 32'h10000, 0));
      send_point(make_point(32'h10000, 0, 0, 32'h10000, 32'h20000, 32'h8000,
                            32'hFFFF8000, 32'h30000, 0));
      send_point(make_point(32'h10000, 0, 0, 32'h10000, 32'h20000, 0, 0, 32'h20000, 1));
      // zero determinant
      send_point(make_point(32'h10000, 32'h20000, 32'h10000, 32'h20000, 32'h10000, 0, 0,
                            32'h10000, 0));
      // saturation high and low
      send_point(make_point(1, 0, 0, 1, 32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 0));
      send_point(make_point(1, 0, 0, 1, 32'h80000000, 0, 0, 32'h7FFFFFFF, 0));
      send_point(make_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                            32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0));
      send_point(make_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                            32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0));
      send_point(make_point(32'hFFFFFFFF, 0, 0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                            32'h80000000, 32'h7FFFFFFF, 0));
      send_point(make_point(0, 32'h10000, 32'hFFFF0000, 0, 0, 32'h30000, 32'h10000, 0, 0));
      // on boundary, with a singular and with a regular reference
      send_point(make_point(0, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 1));
      send_point(make_point(1, 0, 0, 1, 32'h10000, 0, 0, 32'h10000, 1));
   endtask

   task automatic test_threshold_extremes();
      write_threshold(32'd0);
      send_point(make_point(0, 0, 0, 0, 32'h10000, 0, 0, 32'h10000, 0), 1'b0);
      send_point(make_point(1, 0, 0, 1, 32'h10000, 0, 0, 32'h10000, 0), 1'b0);
      write_threshold(32'hFFFF_FFFF);
      send_point(make_point(32'h10000, 0, 0, 32'hFFFF, 32'h10000, 0, 0, 32'h10000, 0));
      send_point(make_point(32'h10000, 0, 0, 32'h10000, 32'h10000, 0, 0, 32'h10000, 0));
      send_point(make_point(32'h10000, 0, 0, 32'h10001, 32'h10000, 0, 0, 32'h10000, 0));
      write_threshold(32'd2);
      send_point(make_point(1, 0, 0, 1, 5, 0, 0, 7, 0));
      send_point(make_point(1, 0, 0, 2, 5, 0, 0, 7, 0));
   endtask

   task automatic test_random(int count, logic [31:0] thr);
      write_threshold(thr);
      repeat (count) send_point(rand_point());
   endtask

   initial begin
      threshold_model = 32'd1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_threshold_extremes();
      test_random(300, 32'd1);
      test_random(300, 32'h0010_0000);
      test_random(300, 32'hFFFF_FFFF);
      test_random(300, $urandom());
      drain();
      $display("Covered %0d mesh points (%0d singular), %0d results checked.",
               n_sent, n_singular, n_checked);
      if (n_err == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule
